>>> rtl/mrps_pkg.sv
// Package: shared constants, types and command/status structs for the range splitter.
`default_nettype none

package mrps_pkg;

    localparam int DEF_TABLE_DEPTH   = 8;
    localparam int DEF_PAGE_BITS     = 12;
    localparam int DEF_MID_PAGE_BITS = 21;
    localparam int DEF_BIG_PAGE_BITS = 30;
    localparam int DEF_ADDRESS_BITS  = 48;

    localparam int ADDR_FIELD_W = 48;
    localparam int CFG_W        = 2;
    localparam int INDEX_W      = 6;
    localparam int TOTAL_W      = 7;
    localparam int S_TDATA_W    = 2 * ADDR_FIELD_W;
    localparam int M_TDATA_W    = INDEX_W + 2 * ADDR_FIELD_W + CFG_W + TOTAL_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET      = 2'b11;
    localparam logic [CFG_W-1:0] ENABLE_MID     = 2'b01;
    localparam logic [CFG_W-1:0] ENABLE_MID_BIG = 2'b11;
    localparam logic [CFG_W-1:0] BITS_SMALL     = 2'b00;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_MID,
        PH_BIG,
        PH_MTAIL,
        PH_TAIL
    } split_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_MID,
        ST_BIG,
        ST_MTAIL,
        ST_TAIL,
        ST_MERGE,
        ST_MWAIT,
        ST_FLUSH,
        ST_EMIT,
        ST_EMPTY
    } ctrl_state_t;

    typedef struct packed {
        logic         load;
        logic         split;
        split_phase_t phase;
        logic         merge_rd;
        logic         merge_proc;
        logic         merge_flush;
        logic         emit;
        logic         emit_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic rd_last;
        logic out_done;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/memory_range_page_splitter.sv
// Top level: range splitter into page-size pieces with merged range table.
// Each range goes through the split phases (head, mid, big, mid tail, tail), a merge pass
//   and a table read before its results appear; a new range is accepted only in idle, once
//   its last result is loaded. Merge and emission share the single read port of the table RAM.
// Empty table: a single result is emitted.
// Reset (aresetn low, synchronous): table emptied, large_page_enable set to 3, output idle.
`default_nettype none

module memory_range_page_splitter
    import mrps_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int PAGE_BITS     = DEF_PAGE_BITS,
    parameter int MID_PAGE_BITS = DEF_MID_PAGE_BITS,
    parameter int BIG_PAGE_BITS = DEF_BIG_PAGE_BITS,
    parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,   // large_page_enable
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // range_start, range_end
    input  wire logic                 s_tuser,     // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // entry_index, entry_base, entry_limit, entry_page_bits, entry_total, overflow
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser,     // entry_valid
    output logic                      m_tlast      // last_entry
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mrps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mrps_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PAGE_BITS     (PAGE_BITS),
        .MID_PAGE_BITS (MID_PAGE_BITS),
        .BIG_PAGE_BITS (BIG_PAGE_BITS),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/mrps_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none

module mrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrps_ctrl.sv
// Controller: sequences load, split phases, merge pass and table emission.
`default_nettype none

module mrps_ctrl
    import mrps_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:  state_next = ST_MID;
            ST_MID:   state_next = ST_BIG;
            ST_BIG:   state_next = ST_MTAIL;
            ST_MTAIL: state_next = ST_TAIL;
            ST_TAIL:  state_next = ST_MERGE;
            ST_MERGE: begin
                priority if (status.count_zero) begin
                    state_next = ST_EMPTY;
                end else if (status.rd_last) begin
                    state_next = ST_MWAIT;
                end else begin
                    state_next = ST_MERGE;
                end
            end
            ST_MWAIT: state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_EMIT;
            ST_EMIT, ST_EMPTY: begin
                if (status.out_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.phase   = PH_HEAD;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_HEAD: begin
                cmd.split = 1'b1;
                cmd.phase = PH_HEAD;
            end
            ST_MID: begin
                cmd.split = 1'b1;
                cmd.phase = PH_MID;
            end
            ST_BIG: begin
                cmd.split = 1'b1;
                cmd.phase = PH_BIG;
            end
            ST_MTAIL: begin
                cmd.split = 1'b1;
                cmd.phase = PH_MTAIL;
            end
            ST_TAIL: begin
                cmd.split = 1'b1;
                cmd.phase = PH_TAIL;
            end
            ST_MERGE: begin
                cmd.merge_rd   = !status.count_zero;
                cmd.merge_proc = 1'b1;
            end
            ST_MWAIT: cmd.merge_proc  = 1'b1;
            ST_FLUSH: cmd.merge_flush = 1'b1;
            ST_EMIT:  cmd.emit        = 1'b1;
            ST_EMPTY: cmd.emit_empty  = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mrps_datapath.sv
// Datapath: page split arithmetic, range table RAM, merge accumulator, output register.
`default_nettype none

module mrps_datapath
    import mrps_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int PAGE_BITS     = DEF_PAGE_BITS,
    parameter int MID_PAGE_BITS = DEF_MID_PAGE_BITS,
    parameter int BIG_PAGE_BITS = DEF_BIG_PAGE_BITS,
    parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int EFF_AW  = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
    localparam int PFN_W   = EFF_AW - PAGE_BITS;
    localparam int MS      = (MID_PAGE_BITS > PAGE_BITS) ? (MID_PAGE_BITS - PAGE_BITS) : 0;
    localparam int BS      = (BIG_PAGE_BITS > PAGE_BITS) ? (BIG_PAGE_BITS - PAGE_BITS) : 0;
    localparam int CALC_W  = ((PFN_W > BS) ? PFN_W : BS) + 1;
    localparam int ENTRY_W = 2 * PFN_W + CFG_W;
    localparam logic [CALC_W-1:0] MS_MASK = CALC_W'((64'd1 << MS) - 64'd1);
    localparam logic [CALC_W-1:0] BS_MASK = CALC_W'((64'd1 << BS) - 64'd1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(TABLE_DEPTH);

    // control registers
    logic [CFG_W-1:0] lpe_reg, lpe_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [IDX_W-1:0] ri_reg, ri_next;
    logic [IDX_W-1:0] wp_reg, wp_next;
    logic             pend_reg, pend_next;
    logic             issued_reg, issued_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [PFN_W-1:0]        pfn_reg, pfn_next;
    logic [PFN_W-1:0]        limit_reg, limit_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [PFN_W-1:0]        acc_start_reg, acc_start_next;
    logic [PFN_W-1:0]        acc_end_reg, acc_end_next;
    logic [CFG_W-1:0]        acc_bits_reg, acc_bits_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic                    out_user_reg, out_user_next;
    logic                    out_last_reg, out_last_next;

    logic [CALC_W-1:0] pfn_x, lim_x, ru_ms, ru_bs, rd_ms, rd_bs, st, en;
    logic [CFG_W-1:0]  piece_bits;
    logic              piece_ok, table_full, split_we;
    logic              mproc, first, joinable, merge_we;
    logic              ram_we, ram_re, emit_rd, out_free, out_load, empty_load, pend_last;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [PFN_W-1:0]  rd_start, rd_end;
    logic [CFG_W-1:0]  rd_bits;

    // split arithmetic
    always_comb begin
        pfn_x = CALC_W'(pfn_reg);
        lim_x = CALC_W'(limit_reg);
        ru_ms = (pfn_x + MS_MASK) & ~MS_MASK;
        ru_bs = (pfn_x + BS_MASK) & ~BS_MASK;
        rd_ms = lim_x & ~MS_MASK;
        rd_bs = lim_x & ~BS_MASK;
        unique case (cmd.phase)
            PH_HEAD: begin
                st         = pfn_x;
                en         = (ru_ms > lim_x) ? lim_x : ru_ms;
                piece_bits = BITS_SMALL;
            end
            PH_MID: begin
                st         = ru_ms;
                en         = (ru_bs > rd_ms) ? rd_ms : ru_bs;
                piece_bits = lpe_reg & ENABLE_MID;
            end
            PH_BIG: begin
                st         = ru_bs;
                en         = rd_bs;
                piece_bits = lpe_reg & ENABLE_MID_BIG;
            end
            PH_MTAIL: begin
                st         = ru_ms;
                en         = rd_ms;
                piece_bits = lpe_reg & ENABLE_MID;
            end
            PH_TAIL: begin
                st         = pfn_x;
                en         = lim_x;
                piece_bits = BITS_SMALL;
            end
            default: begin
                st         = pfn_x;
                en         = pfn_x;
                piece_bits = BITS_SMALL;
            end
        endcase
        piece_ok   = cmd.split && (st < en);
        table_full = (count_reg >= DEPTH_C);
        split_we   = piece_ok && !table_full;
    end

    // table RAM
    assign rd_start = ram_rdata[PFN_W-1:0];
    assign rd_end   = ram_rdata[2*PFN_W-1:PFN_W];
    assign rd_bits  = ram_rdata[ENTRY_W-1:2*PFN_W];

    assign mproc     = cmd.merge_proc && pend_reg;
    assign first     = (pend_idx_reg == '0);
    assign joinable  = (acc_end_reg == rd_start) && (acc_bits_reg == rd_bits);
    assign merge_we  = mproc && !first && !joinable;

    assign status.count_zero = (count_reg == '0);
    assign status.rd_last    = ((CNT_W'(ri_reg) + CNT_W'(1)) == count_reg);
    assign pend_last         = ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == count_reg);

    assign out_free   = !out_valid_reg || m_tready;
    assign out_load   = cmd.emit && pend_reg && out_free;
    assign empty_load = cmd.emit_empty && out_free;
    assign emit_rd    = cmd.emit && !issued_reg && (!pend_reg || out_load);
    assign status.out_done = (out_load && pend_last) || empty_load;

    assign ram_we    = split_we || merge_we || cmd.merge_flush;
    assign ram_waddr = split_we ? count_reg[IDX_W-1:0] : wp_reg;
    assign ram_wdata = split_we ? {piece_bits, en[PFN_W-1:0], st[PFN_W-1:0]}
                                : {acc_bits_reg, acc_end_reg, acc_start_reg};
    assign ram_re    = cmd.merge_rd || emit_rd;

    mrps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ri_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        lpe_next       = cfg_we ? cfg_wdata : lpe_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        ri_next        = ri_reg;
        wp_next        = wp_reg;
        pend_next      = pend_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg;
        pfn_next       = pfn_reg;
        limit_next     = limit_reg;
        pend_idx_next  = pend_idx_reg;
        acc_start_next = acc_start_reg;
        acc_end_next   = acc_end_reg;
        acc_bits_next  = acc_bits_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        if (cmd.load) begin
            pfn_next     = s_tdata[EFF_AW-1:PAGE_BITS];
            limit_next   = s_tdata[ADDR_FIELD_W+EFF_AW-1:ADDR_FIELD_W+PAGE_BITS];
            dropped_next = 1'b0;
            ri_next      = '0;
            wp_next      = '0;
            issued_next  = 1'b0;
            if (s_tuser) begin
                count_next = '0;
            end
        end

        if (piece_ok) begin
            pfn_next = en[PFN_W-1:0];
            if (table_full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (ram_re) begin
            ri_next       = ri_reg + IDX_W'(1);
            pend_idx_next = ri_reg;
            if (emit_rd && status.rd_last) begin
                issued_next = 1'b1;
            end
        end

        if (mproc) begin
            if (first || !joinable) begin
                acc_start_next = rd_start;
                acc_end_next   = rd_end;
                acc_bits_next  = rd_bits;
            end else begin
                acc_end_next = rd_end;
            end
            if (merge_we) begin
                wp_next = wp_reg + IDX_W'(1);
            end
        end

        if (cmd.merge_flush) begin
            count_next  = CNT_W'(wp_reg) + CNT_W'(1);
            ri_next     = '0;
            issued_next = 1'b0;
        end

        if (ram_re) begin
            pend_next = 1'b1;
        end else if (mproc || out_load) begin
            pend_next = 1'b0;
        end

        if (out_load) begin
            out_data_next = {dropped_reg, TOTAL_W'(count_reg), rd_bits,
                             ADDR_FIELD_W'({rd_end, {PAGE_BITS{1'b0}}}),
                             ADDR_FIELD_W'({rd_start, {PAGE_BITS{1'b0}}}),
                             INDEX_W'(pend_idx_reg)};
            out_user_next = 1'b1;
            out_last_next = pend_last;
        end else if (empty_load) begin
            out_data_next = {dropped_reg, {(M_TDATA_W-1){1'b0}}};
            out_user_next = 1'b0;
            out_last_next = 1'b1;
        end

        if (out_load || empty_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpe_reg       <= CFG_RESET;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            ri_reg        <= '0;
            wp_reg        <= '0;
            pend_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            lpe_reg       <= lpe_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            ri_reg        <= ri_next;
            wp_reg        <= wp_next;
            pend_reg      <= pend_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pfn_reg       <= pfn_next;
        limit_reg     <= limit_next;
        pend_idx_reg  <= pend_idx_next;
        acc_start_reg <= acc_start_next;
        acc_end_reg   <= acc_end_next;
        acc_bits_reg  <= acc_bits_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
